>>> rtl/risc_execute_alu_with_carry_core_macros.svh
// Assertion macros for the execute ALU checker.
// Needs a clock and an active-low reset in scope of the user.
`ifndef RISC_EXECUTE_ALU_WITH_CARRY_CORE_MACROS_SVH
`define RISC_EXECUTE_ALU_WITH_CARRY_CORE_MACROS_SVH

// checked only while out of reset
`define REAC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define REAC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/reac_pkg.sv
// Shared constants for the execute ALU: data width, operation codes,
// branch condition codes. No dependencies.
package reac_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int SHAMT_W    = 5;

    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_ADDC   = 4'd1;
    localparam logic [3:0] OP_RSUB   = 4'd2;
    localparam logic [3:0] OP_RSUBC  = 4'd3;
    localparam logic [3:0] OP_CMP    = 4'd4;
    localparam logic [3:0] OP_OR     = 4'd5;
    localparam logic [3:0] OP_AND    = 4'd6;
    localparam logic [3:0] OP_XOR    = 4'd7;
    localparam logic [3:0] OP_ANDN   = 4'd8;
    localparam logic [3:0] OP_SLL    = 4'd9;
    localparam logic [3:0] OP_SRL    = 4'd10;
    localparam logic [3:0] OP_MUL    = 4'd11;
    localparam logic [3:0] OP_MULH   = 4'd12;
    localparam logic [3:0] OP_MULHU  = 4'd13;
    localparam logic [3:0] OP_MULHSU = 4'd14;
    localparam logic [3:0] OP_SEXT   = 4'd15;

    localparam logic [2:0] BR_NONE   = 3'd0;
    localparam logic [2:0] BR_ALWAYS = 3'd1;
    localparam logic [2:0] BR_EQ     = 3'd2;
    localparam logic [2:0] BR_NE     = 3'd3;
    localparam logic [2:0] BR_LT     = 3'd4;
    localparam logic [2:0] BR_NLT    = 3'd5;
    localparam logic [2:0] BR_LE     = 3'd6;
    localparam logic [2:0] BR_GE     = 3'd7;

    localparam logic [DATA_WIDTH-1:0] SIGN_BIT = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef logic [DATA_WIDTH-1:0] t_word;

endpackage

>>> rtl/risc_execute_alu_with_carry_core.sv
// Execute-stage ALU with stored carry flag: input register, one pass of
// ALU/multiplier/branch logic, result register. Depends on reac_pkg.
//
// Each request is latched into the input register, computed combinationally
// and lands in the result register, which drives the outputs; one request is
// taken every clock while the downstream side keeps up. The 33x33 multiplier
// and the carry flag, which is written as a request leaves the input
// register so the next request sees it, set the critical path. A shift
// right that asks for both sign and carry fill returns error with zero result
// and leaves the flag alone.
module risc_execute_alu_with_carry_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_operation,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    input  logic [31:0] i_branch_value,
    input  logic [31:0] i_pc,
    input  logic        i_a_from_pc,
    input  logic        i_b_from_pc,
    input  logic        i_branch_from_pc,
    input  logic        i_is_signed,
    input  logic        i_use_carry,
    input  logic        i_write_carry,
    input  logic [2:0]  i_branch_cond,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result,
    output logic        o_carry_out,
    output logic        o_branch_taken,
    output logic        o_error
);

    localparam int W = reac_pkg::DATA_WIDTH;

    // input register
    logic               r_in_valid;
    logic [3:0]         r_op;
    reac_pkg::t_word    r_a;
    reac_pkg::t_word    r_b;
    reac_pkg::t_word    r_bv;
    logic               r_sgn;
    logic               r_usec;
    logic               r_wc;
    logic [2:0]         r_cond;

    // result register
    logic               r_out_valid;
    reac_pkg::t_word    r_result;
    logic               r_carry_out;
    logic               r_taken;
    logic               r_error;

    logic               r_carry_flag;

    logic               out_free;
    logic               move;

    assign out_free = !r_out_valid || i_ready;
    assign move     = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op   <= i_operation;
            r_a    <= i_a_from_pc ? i_pc : i_operand_a;
            r_b    <= i_b_from_pc ? i_pc : i_operand_b;
            r_bv   <= i_branch_from_pc ? i_pc : i_branch_value;
            r_sgn  <= i_is_signed;
            r_usec <= i_use_carry;
            r_wc   <= i_write_carry;
            r_cond <= i_branch_cond;
        end
    end

    // ---------------- compute ----------------
    logic               n_error;
    reac_pkg::t_word    n_result;
    logic               n_carry;
    logic               n_taken;

    logic               add_cin;
    reac_pkg::t_word    add_x;
    reac_pkg::t_word    add_y;
    logic [W:0]         add_sum;
    logic               lt_cmp;

    logic [reac_pkg::SHAMT_W-1:0] sh;
    reac_pkg::t_word    srl_mask;
    logic               srl_fill;

    logic               ma_sgn;
    logic               mb_sgn;
    logic signed [W:0]  ma;
    logic signed [W:0]  mb;
    logic signed [2*W+1:0] prod;

    logic [reac_pkg::SHAMT_W-1:0] sx_idx;
    logic               sx_in_range;
    reac_pkg::t_word    sx_hi;

    logic               bv_lt;
    logic               bv_eq;

    assign n_error = (r_op == reac_pkg::OP_SRL) && r_sgn && r_usec;

    // shared adder for add / addc / rsub / rsubc / cmp
    always_comb begin
        add_x   = r_a;
        add_y   = r_b;
        add_cin = 1'b0;
        case (r_op)
            reac_pkg::OP_ADDC: begin
                add_cin = r_carry_flag;
            end
            reac_pkg::OP_RSUB: begin
                add_x   = ~r_a;
                add_cin = 1'b1;
            end
            reac_pkg::OP_RSUBC: begin
                add_x   = ~r_a;
                add_cin = r_carry_flag;
            end
            reac_pkg::OP_CMP: begin
                add_y   = ~r_b;
                add_cin = 1'b1;
            end
            default: begin
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{W{1'b0}}, add_cin};
    assign lt_cmp  = r_sgn ? ((r_a ^ reac_pkg::SIGN_BIT) < (r_b ^ reac_pkg::SIGN_BIT))
                           : (r_a < r_b);

    assign sh       = r_b[reac_pkg::SHAMT_W-1:0];
    assign srl_mask = ~({W{1'b1}} >> sh);
    assign srl_fill = r_sgn ? r_a[W-1] : (r_usec && r_carry_flag);

    assign ma_sgn = (r_op == reac_pkg::OP_MULH) || (r_op == reac_pkg::OP_MULHSU);
    assign mb_sgn = (r_op == reac_pkg::OP_MULH);
    assign ma     = $signed({ma_sgn & r_a[W-1], r_a});
    assign mb     = $signed({mb_sgn & r_b[W-1], r_b});
    assign prod   = ma * mb;

    assign sx_in_range = (r_b[W-1:reac_pkg::SHAMT_W] == '0) && (sh != '0);
    assign sx_idx      = sh - {{(reac_pkg::SHAMT_W-1){1'b0}}, 1'b1};
    assign sx_hi       = {W{1'b1}} << sh;

    always_comb begin
        n_result = '0;
        n_carry  = 1'b0;
        case (r_op)
            reac_pkg::OP_ADD, reac_pkg::OP_ADDC,
            reac_pkg::OP_RSUB, reac_pkg::OP_RSUBC: begin
                n_result = add_sum[W-1:0];
                n_carry  = add_sum[W];
            end
            reac_pkg::OP_CMP: begin
                n_result = {lt_cmp, add_sum[W-2:0]};
                n_carry  = add_sum[W];
            end
            reac_pkg::OP_OR:   n_result = r_a | r_b;
            reac_pkg::OP_AND:  n_result = r_a & r_b;
            reac_pkg::OP_XOR:  n_result = r_a ^ r_b;
            reac_pkg::OP_ANDN: n_result = r_a & ~r_b;
            reac_pkg::OP_SLL:  n_result = r_a << sh;
            reac_pkg::OP_SRL: begin
                n_result = (r_a >> sh) | (srl_fill ? srl_mask : '0);
                n_carry  = |(r_a & ~({W{1'b1}} << sh));
            end
            reac_pkg::OP_MUL:  n_result = prod[W-1:0];
            reac_pkg::OP_MULH, reac_pkg::OP_MULHU,
            reac_pkg::OP_MULHSU: begin
                n_result = prod[2*W-1:W];
            end
            reac_pkg::OP_SEXT: begin
                if (sx_in_range) begin
                    n_result = r_a[sx_idx] ? (r_a | sx_hi) : (r_a & ~sx_hi);
                end else begin
                    n_result = r_a;
                end
            end
            default: n_result = '0;
        endcase
        if (n_error) begin
            n_result = '0;
            n_carry  = 1'b0;
        end
    end

    // branch test on the selected value, taken as signed
    assign bv_lt = r_bv[W-1];
    assign bv_eq = (r_bv == '0);

    always_comb begin
        case (r_cond)
            reac_pkg::BR_NONE:   n_taken = 1'b0;
            reac_pkg::BR_ALWAYS: n_taken = 1'b1;
            reac_pkg::BR_EQ:     n_taken = bv_eq;
            reac_pkg::BR_NE:     n_taken = !bv_eq;
            reac_pkg::BR_LT:     n_taken = bv_lt;
            reac_pkg::BR_NLT:    n_taken = !bv_lt;
            reac_pkg::BR_LE:     n_taken = bv_eq || bv_lt;
            reac_pkg::BR_GE:     n_taken = bv_eq || !bv_lt;
            default:             n_taken = 1'b0;
        endcase
        if (n_error) begin
            n_taken = 1'b0;
        end
    end

    // ---------------- result register and flag ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_carry_flag <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (move && r_wc && !n_error) begin
                r_carry_flag <= n_carry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_result    <= n_result;
            r_carry_out <= n_carry;
            r_taken     <= n_taken;
            r_error     <= n_error;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result       = r_result;
    assign o_carry_out    = r_carry_out;
    assign o_branch_taken = r_taken;
    assign o_error        = r_error;

endmodule

>>> rtl/reac_checker.sv
// Port-level checker for the execute ALU, bound to the core module.
// Uses risc_execute_alu_with_carry_core_macros.svh.
`include "risc_execute_alu_with_carry_core_macros.svh"

module reac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_result,
    input logic        o_carry_out,
    input logic        o_branch_taken,
    input logic        o_error
);

    // a result held back by the consumer stays put
    `REAC_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_result) && $stable(o_error), "stalled result changed")

    // an error request carries no result, carry or branch
    `REAC_ASSERT(a_err_clean, i_clk, i_rst_n, o_valid && o_error |-> o_result == 32'd0 && !o_carry_out && !o_branch_taken, "error request with nonzero outputs")

    // with the result side empty the input side must accept
    `REAC_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_valid |-> o_ready, "input stalled while output empty")

    // nothing comes out right after reset
    `REAC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind risc_execute_alu_with_carry_core reac_checker u_reac_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_result       (o_result),
    .o_carry_out    (o_carry_out),
    .o_branch_taken (o_branch_taken),
    .o_error        (o_error)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for risc_execute_alu_with_carry_core: random and directed requests,
// scoreboard fed by an in-bench ALU predictor. Depends on reac_pkg and the core.
module tb_top;

    localparam int IDLE_LIMIT   = 1000;
    localparam int N_RANDOM     = 1000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [3:0]       op;
        reac_pkg::t_word  a;
        reac_pkg::t_word  b;
        reac_pkg::t_word  bv;
        reac_pkg::t_word  pc;
        logic             a_pc;
        logic             b_pc;
        logic             bv_pc;
        logic             sgn;
        logic             usec;
        logic             wc;
        logic [2:0]       cond;
    } t_alu_req;

    typedef struct packed {
        reac_pkg::t_word result;
        logic            carry;
        logic            taken;
        logic            err;
    } t_alu_res;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_ready;
    logic [3:0]  i_operation      = '0;
    logic [31:0] i_operand_a      = '0;
    logic [31:0] i_operand_b      = '0;
    logic [31:0] i_branch_value   = '0;
    logic [31:0] i_pc             = '0;
    logic        i_a_from_pc      = 1'b0;
    logic        i_b_from_pc      = 1'b0;
    logic        i_branch_from_pc = 1'b0;
    logic        i_is_signed      = 1'b0;
    logic        i_use_carry      = 1'b0;
    logic        i_write_carry    = 1'b0;
    logic [2:0]  i_branch_cond    = '0;
    logic        o_valid;
    logic        i_ready          = 1'b0;
    logic [31:0] o_result;
    logic        o_carry_out;
    logic        o_branch_taken;
    logic        o_error;

    t_alu_req req_pending_q[$];
    t_alu_res alu_expect_q[$];
    logic     carry_model = 1'b0;
    int       mismatch_cnt = 0;
    bit       req_fire = 1'b0;
    bit       resp_fire = 1'b0;
    int       idle_cycles = 0;

    risc_execute_alu_with_carry_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_operand_a      (i_operand_a),
        .i_operand_b      (i_operand_b),
        .i_branch_value   (i_branch_value),
        .i_pc             (i_pc),
        .i_a_from_pc      (i_a_from_pc),
        .i_b_from_pc      (i_b_from_pc),
        .i_branch_from_pc (i_branch_from_pc),
        .i_is_signed      (i_is_signed),
        .i_use_carry      (i_use_carry),
        .i_write_carry    (i_write_carry),
        .i_branch_cond    (i_branch_cond),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result         (o_result),
        .o_carry_out      (o_carry_out),
        .o_branch_taken   (o_branch_taken),
        .o_error          (o_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Computes what the core returns for one request and advances the carry flag.
    function automatic t_alu_res predict_alu(t_alu_req q);
        t_alu_res         res;
        reac_pkg::t_word  a;
        reac_pkg::t_word  b;
        reac_pkg::t_word  bv;
        reac_pkg::t_word  r;
        reac_pkg::t_word  hi;
        logic             c;
        logic             lt;
        logic             eq;
        logic             take;
        logic             fill;
        logic [32:0]      s;
        logic [63:0]      p;
        logic [4:0]       sh;
        a   = q.a_pc  ? q.pc : q.a;
        b   = q.b_pc  ? q.pc : q.b;
        bv  = q.bv_pc ? q.pc : q.bv;
        res = '0;
        r   = '0;
        c   = 1'b0;
        sh  = b[4:0];
        if (q.op == reac_pkg::OP_SRL && q.sgn && q.usec) begin
            res.err = 1'b1;
            return res;
        end
        case (q.op)
            reac_pkg::OP_ADD: begin
                s = {1'b0, a} + {1'b0, b};
                r = s[31:0]; c = s[32];
            end
            reac_pkg::OP_ADDC: begin
                s = {1'b0, a} + {1'b0, b} + {32'd0, carry_model};
                r = s[31:0]; c = s[32];
            end
            reac_pkg::OP_RSUB: begin
                s = {1'b0, ~a} + {1'b0, b} + 33'd1;
                r = s[31:0]; c = s[32];
            end
            reac_pkg::OP_RSUBC: begin
                s = {1'b0, ~a} + {1'b0, b} + {32'd0, carry_model};
                r = s[31:0]; c = s[32];
            end
            reac_pkg::OP_CMP: begin
                s  = {1'b0, a} + {1'b0, ~b} + 33'd1;
                lt = q.sgn ? ($signed(a) < $signed(b)) : (a < b);
                r  = {lt, s[30:0]};
                c  = s[32];
            end
            reac_pkg::OP_OR:   r = a | b;
            reac_pkg::OP_AND:  r = a & b;
            reac_pkg::OP_XOR:  r = a ^ b;
            reac_pkg::OP_ANDN: r = a & ~b;
            reac_pkg::OP_SLL:  r = a << sh;
            reac_pkg::OP_SRL: begin
                r    = a >> sh;
                fill = 1'b0;
                if (q.usec) fill = carry_model;
                if (q.sgn)  fill = a[31];
                if (fill && sh != 5'd0) r = r | ~(32'hFFFF_FFFF >> sh);
                c = ((a & ((32'd1 << sh) - 32'd1)) != 32'd0);
            end
            reac_pkg::OP_MUL: begin
                p = {32'd0, a} * {32'd0, b};
                r = p[31:0];
            end
            reac_pkg::OP_MULH: begin
                p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                r = p[63:32];
            end
            reac_pkg::OP_MULHU: begin
                p = {32'd0, a} * {32'd0, b};
                r = p[63:32];
            end
            reac_pkg::OP_MULHSU: begin
                p = {{32{a[31]}}, a} * {32'd0, b};
                r = p[63:32];
            end
            default: begin
                if (b >= 32'd1 && b <= 32'd31) begin
                    hi = 32'hFFFF_FFFF << sh;
                    r  = a[sh - 5'd1] ? (a | hi) : (a & ~hi);
                end else begin
                    r = a;
                end
            end
        endcase
        if (q.wc) carry_model = c;
        lt = bv[31];
        eq = (bv == '0);
        case (q.cond)
            reac_pkg::BR_ALWAYS: take = 1'b1;
            reac_pkg::BR_EQ:     take = eq;
            reac_pkg::BR_NE:     take = !eq;
            reac_pkg::BR_LT:     take = lt;
            reac_pkg::BR_NLT:    take = !lt;
            reac_pkg::BR_LE:     take = eq || lt;
            reac_pkg::BR_GE:     take = eq || !lt;
            default:             take = 1'b0;
        endcase
        res.result = r;
        res.carry  = c;
        res.taken  = take;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("t=%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    function automatic t_alu_req mk_req(logic [3:0] op, reac_pkg::t_word a,
                                        reac_pkg::t_word b);
        t_alu_req q;
        q    = '0;
        q.op = op;
        q.a  = a;
        q.b  = b;
        return q;
    endfunction

    function automatic reac_pkg::t_word rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return reac_pkg::t_word'($urandom_range(0, 40));
            default: return $urandom;
        endcase
    endfunction

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : $urandom_range(0, 10);
    endfunction

    // Monitor: records handshakes, predicts on each accepted request and
    // checks each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_alu_res want;
        if (!i_rst_n) begin
            req_fire  = 1'b0;
            resp_fire = 1'b0;
        end else begin
            req_fire  = i_valid && o_ready;
            resp_fire = o_valid && i_ready;
            if (resp_fire) begin
                if (alu_expect_q.size() == 0) begin
                    report_mismatch("unexpected result", o_result, '0);
                end else begin
                    want = alu_expect_q.pop_front();
                    if (o_result !== want.result)
                        report_mismatch("result", o_result, want.result);
                    if (o_carry_out !== want.carry)
                        report_mismatch("carry_out", 32'(o_carry_out), 32'(want.carry));
                    if (o_branch_taken !== want.taken)
                        report_mismatch("branch_taken", 32'(o_branch_taken), 32'(want.taken));
                    if (o_error !== want.err)
                        report_mismatch("error", 32'(o_error), 32'(want.err));
                end
            end
            if (req_fire)
                alu_expect_q.push_back(predict_alu({i_operation, i_operand_a, i_operand_b,
                    i_branch_value, i_pc, i_a_from_pc, i_b_from_pc, i_branch_from_pc,
                    i_is_signed, i_use_carry, i_write_carry, i_branch_cond}));
            if (req_fire || resp_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Request driver: holds each request until taken, then waits its drawn gap.
    int       src_gap   = 0;
    bit       src_quiet = 1'b0;
    always @(negedge i_clk) begin
        t_alu_req cur;
        if (i_rst_n && (!i_valid || req_fire)) begin
            if (i_valid) begin
                if ($urandom_range(0, 39) == 0) src_quiet = ~src_quiet;
                src_gap = draw_wait(src_quiet);
            end
            if (src_gap > 0) begin
                src_gap--;
                i_valid <= 1'b0;
            end else if (req_pending_q.size() != 0) begin
                cur = req_pending_q.pop_front();
                i_operation      <= cur.op;
                i_operand_a      <= cur.a;
                i_operand_b      <= cur.b;
                i_branch_value   <= cur.bv;
                i_pc             <= cur.pc;
                i_a_from_pc      <= cur.a_pc;
                i_b_from_pc      <= cur.b_pc;
                i_branch_from_pc <= cur.bv_pc;
                i_is_signed      <= cur.sgn;
                i_use_carry      <= cur.usec;
                i_write_carry    <= cur.wc;
                i_branch_cond    <= cur.cond;
                i_valid          <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result side: stalls for a drawn wait after each result.
    int       snk_stall = 0;
    bit       snk_quiet = 1'b0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (resp_fire) begin
                if ($urandom_range(0, 39) == 0) snk_quiet = ~snk_quiet;
                snk_stall = draw_wait(snk_quiet);
            end
            if (snk_stall > 0) begin
                snk_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_alu_req q;
        t_alu_req directed[$];
        // carry chain: set, consume, rsub corners
        q = mk_req(reac_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h1);
        q.wc = 1; directed.push_back(q);
        q = mk_req(reac_pkg::OP_ADDC, 32'h0, 32'h0);
        q.wc = 1; directed.push_back(q);
        q = mk_req(reac_pkg::OP_RSUB, 32'h0, 32'h0);
        q.wc = 1; directed.push_back(q);
        q = mk_req(reac_pkg::OP_RSUBC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        q.wc = 1; directed.push_back(q);
        q = mk_req(reac_pkg::OP_CMP, 32'h8000_0000, 32'h7FFF_FFFF);
        q.sgn = 1; directed.push_back(q);
        q = mk_req(reac_pkg::OP_CMP, 32'h8000_0000, 32'h7FFF_FFFF); directed.push_back(q);
        q = mk_req(reac_pkg::OP_OR, 32'hFFFF_0000, 32'h0000_FFFF); directed.push_back(q);
        q = mk_req(reac_pkg::OP_AND, 32'hFFFF_FFFF, 32'h8000_0001); directed.push_back(q);
        q = mk_req(reac_pkg::OP_XOR, 32'hFFFF_FFFF, 32'h5555_AAAA); directed.push_back(q);
        q = mk_req(reac_pkg::OP_ANDN, 32'hFFFF_FFFF, 32'h0F0F_0F0F); directed.push_back(q);
        q = mk_req(reac_pkg::OP_SLL, 32'hFFFF_FFFF, 32'd31); directed.push_back(q);
        q = mk_req(reac_pkg::OP_SLL, 32'h1234_5678, 32'd32); directed.push_back(q);
        // carry fill with the flag set first
        q = mk_req(reac_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000);
        q.wc = 1; directed.push_back(q);
        q = mk_req(reac_pkg::OP_SRL, 32'h0000_00F1, 32'd4);
        q.usec = 1; directed.push_back(q);
        q = mk_req(reac_pkg::OP_SRL, 32'hFFFF_FFFF, 32'd0);
        q.usec = 1; directed.push_back(q);
        q = mk_req(reac_pkg::OP_SRL, 32'h8000_0000, 32'd31);
        q.sgn = 1; directed.push_back(q);
        // signed carry shift: error, flag must stay put
        q = mk_req(reac_pkg::OP_SRL, 32'hFFFF_FFFF, 32'd3);
        q.sgn = 1; q.usec = 1; q.wc = 1; q.cond = reac_pkg::BR_ALWAYS; directed.push_back(q);
        q = mk_req(reac_pkg::OP_ADDC, 32'h0, 32'h0); directed.push_back(q);
        q = mk_req(reac_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF); directed.push_back(q);
        q = mk_req(reac_pkg::OP_MULH, 32'h8000_0000, 32'h8000_0000); directed.push_back(q);
        q = mk_req(reac_pkg::OP_MULHU, 32'hFFFF_FFFF, 32'hFFFF_FFFF); directed.push_back(q);
        q = mk_req(reac_pkg::OP_MULHSU, 32'hFFFF_FFFF, 32'hFFFF_FFFF); directed.push_back(q);
        q = mk_req(reac_pkg::OP_SEXT, 32'h0000_0080, 32'd8); directed.push_back(q);
        q = mk_req(reac_pkg::OP_SEXT, 32'h0000_0001, 32'd1); directed.push_back(q);
        q = mk_req(reac_pkg::OP_SEXT, 32'h4000_0000, 32'd31); directed.push_back(q);
        q = mk_req(reac_pkg::OP_SEXT, 32'hFFFF_00FF, 32'd0); directed.push_back(q);
        q = mk_req(reac_pkg::OP_SEXT, 32'h0000_00FF, 32'hFFFF_FFFF); directed.push_back(q);
        // pc selects
        q = mk_req(reac_pkg::OP_ADD, 32'h0, 32'h0);
        q.pc = 32'hFFFF_FFFC; q.a_pc = 1; q.b_pc = 1; q.bv_pc = 1; directed.push_back(q);
        foreach (directed[i]) begin
            q = directed[i];
            q.cond = 3'(i % 8);
            if (!q.bv_pc) begin
                case (i % 3)
                    0: q.bv = 32'h0;
                    1: q.bv = 32'h8000_0000;
                    default: q.bv = 32'h7FFF_FFFF;
                endcase
            end
            req_pending_q.push_back(q);
        end
        repeat (N_RANDOM) begin
            q.op    = 4'($urandom_range(0, 15));
            q.a     = rand_word();
            q.b     = ($urandom_range(0, 3) == 0) ?
                      reac_pkg::t_word'($urandom_range(0, 33)) : rand_word();
            q.bv    = rand_word();
            q.pc    = $urandom;
            q.a_pc  = ($urandom_range(0, 4) == 0);
            q.b_pc  = ($urandom_range(0, 4) == 0);
            q.bv_pc = ($urandom_range(0, 3) == 0);
            q.sgn   = 1'($urandom);
            q.usec  = 1'($urandom);
            q.wc    = 1'($urandom);
            q.cond  = 3'($urandom_range(0, 7));
            req_pending_q.push_back(q);
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_pending_q.size() != 0 || i_valid || alu_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && alu_expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> risc_execute_alu_with_carry_core.f
+incdir+rtl
rtl/reac_pkg.sv
rtl/risc_execute_alu_with_carry_core.sv
rtl/reac_checker.sv
tb/tb_top.sv
